// ===== design/krt_pkg.sv =====
// Shared codes and controller/datapath interface types for the keyed record table.
package krt_pkg;

  // request codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // result slot source
  localparam logic [1:0] SLOT_ZERO = 2'd0;
  localparam logic [1:0] SLOT_IDX  = 2'd1;
  localparam logic [1:0] SLOT_CNT  = 2'd2;
  localparam logic [1:0] SLOT_POS  = 2'd3;

  // field widths
  localparam int KEY_W   = 32;
  localparam int AGE_W   = 8;
  localparam int SCORE_W = 32;
  localparam int CAP_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int CNTO_W  = 5;
  localparam int ENTRY_W = KEY_W + AGE_W + SCORE_W;

  // controller -> datapath
  typedef struct packed {
    logic       ld;         // latch request, clear scan index
    logic       rd;         // read entry at scan index
    logic       adv;        // step scan index
    logic       mark;       // remember scan index as removed slot
    logic       wr_ins;     // append request record at count
    logic       wr_shift;   // move read entry down one place
    logic       fin;        // load result registers
    logic [1:0] fin_status;
    logic [1:0] slot_sel;
    logic       take_data;  // report the read entry's age and score
    logic       cnt_inc;
    logic       cnt_dec;
  } krt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;        // read entry key equals request key
    logic       last;       // scan index is the last valid entry
    logic       empty;
    logic       full;
    logic       shift_end;  // scan index reached count
  } krt_stat_t;

endpackage

// ===== design/krt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/krt_ctrl.sv =====
// Sequencer for lookup, insert and delete: scans entries and steers the datapath.
module krt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  krt_pkg::krt_stat_t stat,
  output krt_pkg::krt_cmd_t  cmd
);
  import krt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld    = 1'b1;
          state_nxt = S_DISP;
        end
      end

      // early outcomes before any entry is read
      S_DISP: begin
        state_nxt = S_IDLE;
        if (stat.cmd == CMD_NOP) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_OK;
        end else if (stat.cmd == CMD_INSERT && stat.full) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
        end else if (stat.empty) begin
          cmd.fin = 1'b1;
          if (stat.cmd == CMD_INSERT) begin
            cmd.wr_ins     = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.fin_status = ST_OK;
            cmd.slot_sel   = SLOT_CNT;
          end else begin
            cmd.fin_status = ST_MISS;
          end
        end else begin
          cmd.fin   = 1'b0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end

      // compare one entry
      S_CMP: begin
        if (stat.hit) begin
          case (stat.cmd)
            CMD_LOOKUP: begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_OK;
              cmd.slot_sel   = SLOT_IDX;
              cmd.take_data  = 1'b1;
              state_nxt      = S_IDLE;
            end
            CMD_INSERT: begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_DUP;
              state_nxt      = S_IDLE;
            end
            default: begin
              cmd.mark  = 1'b1;
              cmd.adv   = 1'b1;
              state_nxt = S_SH_RD;
            end
          endcase
        end else if (stat.last) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
          if (stat.cmd == CMD_INSERT) begin
            cmd.wr_ins     = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.fin_status = ST_OK;
            cmd.slot_sel   = SLOT_CNT;
          end else begin
            cmd.fin_status = ST_MISS;
          end
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_RD;
        end
      end

      // close the gap left by a delete, one entry per pass
      S_SH_RD: begin
        if (stat.shift_end) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.slot_sel   = SLOT_POS;
          cmd.cnt_dec    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.adv      = 1'b1;
        state_nxt    = S_SH_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/krt_dp.sv =====
// Datapath: request latch, scan index, entry RAM, count and result registers.
module krt_dp #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  krt_pkg::krt_cmd_t                   cmd,
  output krt_pkg::krt_stat_t                  stat,
  input  logic [krt_pkg::CAP_W-1:0]          cap,
  input  logic [1:0]                         in_cmd,
  input  logic [krt_pkg::KEY_W-1:0]          in_key,
  input  logic [krt_pkg::AGE_W-1:0]          in_new_age,
  input  logic [krt_pkg::SCORE_W-1:0]        in_new_score_bits,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [krt_pkg::SLOT_W-1:0]         out_slot,
  output logic [krt_pkg::AGE_W-1:0]          out_found_age,
  output logic [krt_pkg::SCORE_W-1:0]        out_found_score_bits,
  output logic [krt_pkg::CNTO_W-1:0]         out_count_now
);
  import krt_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int SW   = (AW > SLOT_W) ? AW : SLOT_W;

  // request latch
  logic [1:0]         cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [AGE_W-1:0]   age_r;
  logic [SCORE_W-1:0] score_r;

  // scan state and count
  logic [CW-1:0] idx_r;
  logic [AW-1:0] pos_r;
  logic [CW-1:0] count_r, count_nxt;

  // result registers
  logic                valid_r;
  logic [1:0]          status_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [AGE_W-1:0]    fage_r;
  logic [SCORE_W-1:0]  fscore_r;
  logic [CNTO_W-1:0]   cnt_out_r;

  // RAM ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [CW-1:0]      idx_prev;
  logic [KEY_W-1:0]   rd_key;
  logic [AGE_W-1:0]   rd_age;
  logic [SCORE_W-1:0] rd_score;

  // result formatting
  logic [AW-1:0]   slot_sel_val;
  logic [SW-1:0]   slot_ext;
  logic [CMPW-1:0] cnt_ext;

  assign rd_key   = rd_data[ENTRY_W-1 -: KEY_W];
  assign rd_age   = rd_data[SCORE_W +: AGE_W];
  assign rd_score = rd_data[SCORE_W-1:0];

  // write port: append at count, or move an entry down one place
  assign idx_prev = idx_r - CW'(1);
  assign wr_en    = cmd.wr_ins | cmd.wr_shift;
  assign wr_addr  = cmd.wr_ins ? count_r[AW-1:0] : idx_prev[AW-1:0];
  assign wr_data  = cmd.wr_ins ? {key_r, age_r, score_r} : rd_data;

  krt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // status back to the sequencer
  assign stat.cmd       = cmd_r;
  assign stat.hit       = (rd_key == key_r);
  assign stat.last      = ((idx_r + CW'(1)) >= count_r);
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (CMPW'(count_r) >= CMPW'(cap)) || (count_r >= CW'(DEPTH));
  assign stat.shift_end = (idx_r >= count_r);

  // request latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      age_r   <= in_new_age;
      score_r <= in_new_score_bits;
      idx_r   <= '0;
    end else if (cmd.adv) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.mark) begin
      pos_r <= idx_r[AW-1:0];
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // slot source and field masking
  always_comb begin
    case (cmd.slot_sel)
      SLOT_IDX: slot_sel_val = idx_r[AW-1:0];
      SLOT_CNT: slot_sel_val = count_r[AW-1:0];
      SLOT_POS: slot_sel_val = pos_r;
      default:  slot_sel_val = '0;
    endcase
  end

  assign slot_ext = SW'(slot_sel_val);
  assign cnt_ext  = CMPW'(count_nxt);

  // result beat, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status_r  <= cmd.fin_status;
      slot_r    <= slot_ext[SLOT_W-1:0];
      fage_r    <= cmd.take_data ? rd_age : '0;
      fscore_r  <= cmd.take_data ? rd_score : '0;
      cnt_out_r <= cnt_ext[CNTO_W-1:0];
    end
  end

  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_slot             = slot_r;
  assign out_found_age        = fage_r;
  assign out_found_score_bits = fscore_r;
  assign out_count_now        = cnt_out_r;

endmodule

// ===== design/keyed_record_table_unit.sv =====
// Top level of the keyed record table: register port, sequencer and datapath.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------------------
//   request  | start / busy                  | in_cmd, in_key, in_new_age, in_new_score_bits
//   result   | out_valid (one-cycle strobe)  | out_status, out_slot, out_found_age,
//            |                               | out_found_score_bits, out_count_now
//   register | psel, penable, pwrite, pready | paddr, pwdata, prdata (capacity_limit at 0)
//
// A request beat is taken when start is high and busy is low. Entries are read and
// compared from slot 0 until a hit or the last entry; a delete then moves each later
// entry down one place. Entries sit in one RAM with a single registered read port,
// read one at a time; one request at a time.
// Reset (synchronous, rst_n low) empties the table and sets capacity_limit to 16;
// entry storage is not cleared. The result beat is never held off.
module keyed_record_table_unit #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic [krt_pkg::KEY_W-1:0]    in_key,
  input  logic [krt_pkg::AGE_W-1:0]    in_new_age,
  input  logic [krt_pkg::SCORE_W-1:0]  in_new_score_bits,
  // result
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [krt_pkg::SLOT_W-1:0]   out_slot,
  output logic [krt_pkg::AGE_W-1:0]    out_found_age,
  output logic [krt_pkg::SCORE_W-1:0]  out_found_score_bits,
  output logic [krt_pkg::CNTO_W-1:0]   out_count_now,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import krt_pkg::*;

  localparam logic CAP_REG_IDX = 1'b0;

  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;
  krt_cmd_t         cmd;
  krt_stat_t        stat;

  // capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == CAP_REG_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_wr) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CAP_REG_IDX) ? 32'(cap_r) : '0;

  krt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  krt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cap                  (cap_r),
    .in_cmd               (in_cmd),
    .in_key               (in_key),
    .in_new_age           (in_new_age),
    .in_new_score_bits    (in_new_score_bits),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_found_age        (out_found_age),
    .out_found_score_bits (out_found_score_bits),
    .out_count_now        (out_count_now)
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the keyed record table: directed rows, then random phases checked by a predictor.
module tb;
  import krt_pkg::*;

  localparam int DEPTH = 16;
  localparam int POOL_N = 24;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;
  localparam logic [2:0] CAP_ADDR = 3'd0;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [AGE_W-1:0]   age;
    logic [SCORE_W-1:0] score;
    logic [CNTO_W-1:0]  count;
  } reply_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [AGE_W-1:0]   age;
    logic [SCORE_W-1:0] score;
    bit                 typed;
    reply_t             want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [1:0]          in_cmd = CMD_NOP;
  logic [KEY_W-1:0]    in_key = '0;
  logic [AGE_W-1:0]    in_new_age = '0;
  logic [SCORE_W-1:0]  in_new_score_bits = '0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = CAP_ADDR;
  logic [31:0]         pwdata = '0;
  logic                busy;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [AGE_W-1:0]    out_found_age;
  logic [SCORE_W-1:0]  out_found_score_bits;
  logic [CNTO_W-1:0]   out_count_now;
  logic [31:0]         prdata;
  logic                pready;

  // predicted table contents and capacity register
  logic [KEY_W-1:0]    tbl_key [DEPTH];
  logic [AGE_W-1:0]    tbl_age [DEPTH];
  logic [SCORE_W-1:0]  tbl_score [DEPTH];
  int                  tbl_count = 0;
  logic [CAP_W-1:0]    cap_limit = 5'd16;

  reply_t              pending_replies [$];
  row_t                directed_rows [$];
  reply_t              head_reply;
  logic [KEY_W-1:0]    key_pool [POOL_N];
  logic [CAP_W-1:0]    cap_plan [PHASES] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd7,
                                             5'd31, 5'd2, 5'd12, 5'd16, 5'd4};
  int                  mismatches = 0;

  keyed_record_table_unit #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_new_age(in_new_age),
    .in_new_score_bits(in_new_score_bits),
    .out_valid(out_valid), .out_status(out_status), .out_slot(out_slot),
    .out_found_age(out_found_age), .out_found_score_bits(out_found_score_bits),
    .out_count_now(out_count_now),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the predicted table and return its result
  function automatic reply_t apply_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                           input logic [AGE_W-1:0] age,
                                           input logic [SCORE_W-1:0] score);
    reply_t r;
    int pos;
    r = '0;
    pos = DEPTH;
    // first match wins
    for (int i = 0; i < tbl_count; i++)
      if (pos == DEPTH && tbl_key[i] == key) pos = i;
    case (cmd)
      CMD_LOOKUP: begin
        if (pos < DEPTH) begin
          r.slot = pos[SLOT_W-1:0];
          r.age = tbl_age[pos];
          r.score = tbl_score[pos];
        end else begin
          r.status = ST_MISS;
        end
      end
      CMD_INSERT: begin
        // full check has priority over duplicate
        if (tbl_count >= cap_limit || tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < DEPTH) begin
          r.status = ST_DUP;
        end else begin
          tbl_key[tbl_count] = key;
          tbl_age[tbl_count] = age;
          tbl_score[tbl_count] = score;
          r.slot = tbl_count[SLOT_W-1:0];
          tbl_count++;
        end
      end
      CMD_DELETE: begin
        if (pos < DEPTH) begin
          // close the gap, keeping order
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_age[i] = tbl_age[i + 1];
            tbl_score[i] = tbl_score[i + 1];
          end
          tbl_count--;
          r.slot = pos[SLOT_W-1:0];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    r.count = tbl_count[CNTO_W-1:0];
    return r;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // keys biased toward live entries and a small pool so hits and duplicates are common
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (r < 9) return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  function automatic reply_t mk_reply(input logic [1:0] st, input int sl, input logic [7:0] ag,
                                      input logic [31:0] sc, input int cn);
    reply_t r;
    r.status = st;
    r.slot = sl[SLOT_W-1:0];
    r.age = ag;
    r.score = sc;
    r.count = cn[CNTO_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic [AGE_W-1:0] age, input logic [SCORE_W-1:0] score,
                         input bit typed, input reply_t want);
    row_t row;
    row.cmd = cmd;
    row.key = key;
    row.age = age;
    row.score = score;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // drive one request beat, record its expected result, then idle for gap cycles
  task automatic issue(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [AGE_W-1:0] age, input logic [SCORE_W-1:0] score,
                       input bit typed, input reply_t want, input int gap);
    reply_t predicted;
    in_cmd <= cmd;
    in_key <= key;
    in_new_age <= age;
    in_new_score_bits <= score;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(cmd, key, age, score);
    pending_replies.push_back(typed ? want : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one register access: setup then access phase
  task automatic cfg_cycle(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAP_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [31:0] rd;
    // upper data bits are don't-care
    cfg_cycle(1'b1, ($urandom() & ~32'h1F) | 32'(cap), rd);
    cap_limit = cap;
    cfg_cycle(1'b0, 32'd0, rd);
    if (rd !== 32'(cap)) begin
      $error("capacity_limit: expected %0d, got %0d", cap, rd);
      mismatches++;
    end
  endtask

  task automatic wait_idle();
    while (pending_replies.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with no request pending");
        mismatches++;
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_status !== head_reply.status) begin
          $error("status: expected %0d, got %0d", head_reply.status, out_status);
          mismatches++;
        end
        if (out_slot !== head_reply.slot) begin
          $error("slot: expected %0d, got %0d", head_reply.slot, out_slot);
          mismatches++;
        end
        if (out_found_age !== head_reply.age) begin
          $error("found_age: expected %0d, got %0d", head_reply.age, out_found_age);
          mismatches++;
        end
        if (out_found_score_bits !== head_reply.score) begin
          $error("found_score_bits: expected %h, got %h", head_reply.score,
                 out_found_score_bits);
          mismatches++;
        end
        if (out_count_now !== head_reply.count) begin
          $error("count_now: expected %0d, got %0d", head_reply.count, out_count_now);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [31:0] rd;
    row_t row;
    reply_t none;
    logic [1:0] cmd;
    logic [AGE_W-1:0] age;
    int r;
    int n;
    bit quiet;

    none = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // capacity comes up at 16
    cfg_cycle(1'b0, 32'd0, rd);
    if (rd !== 32'd16) begin
      $error("capacity_limit: expected %0d, got %0d", 16, rd);
      mismatches++;
    end

    // directed: empty table, extremes, duplicate, delete, fill to depth, full
    add_row(CMD_LOOKUP, 32'h0, 8'h0, 32'h0, 1, mk_reply(ST_MISS, 0, 8'h0, 32'h0, 0));
    add_row(CMD_DELETE, '1, 8'h0, 32'h0, 1, mk_reply(ST_MISS, 0, 8'h0, 32'h0, 0));
    add_row(CMD_NOP, '1, 8'hFF, '1, 1, mk_reply(ST_OK, 0, 8'h0, 32'h0, 0));
    add_row(CMD_INSERT, 32'h0, 8'h0, 32'h0, 1, mk_reply(ST_OK, 0, 8'h0, 32'h0, 1));
    add_row(CMD_INSERT, '1, 8'hFF, '1, 1, mk_reply(ST_OK, 1, 8'h0, 32'h0, 2));
    add_row(CMD_INSERT, 32'h0, 8'h12, 32'h5A5A_5A5A, 1, mk_reply(ST_DUP, 0, 8'h0, 32'h0, 2));
    add_row(CMD_LOOKUP, '1, 8'h0, 32'h0, 1, mk_reply(ST_OK, 1, 8'hFF, '1, 2));
    add_row(CMD_DELETE, 32'h0, 8'h0, 32'h0, 1, mk_reply(ST_OK, 0, 8'h0, 32'h0, 1));
    add_row(CMD_LOOKUP, '1, 8'h0, 32'h0, 1, mk_reply(ST_OK, 0, 8'hFF, '1, 1));
    for (int i = 1; i < DEPTH; i++)
      add_row(CMD_INSERT, 32'h1000 + i, 8'(i * 17), $urandom(), 0, none);
    add_row(CMD_INSERT, '1, 8'h1, 32'h1, 1, mk_reply(ST_FULL, 0, 8'h0, 32'h0, 16));
    add_row(CMD_INSERT, 32'h1234_5678, 8'h1, 32'h1, 1,
            mk_reply(ST_FULL, 0, 8'h0, 32'h0, 16));
    add_row(CMD_LOOKUP, 32'h100F, 8'h0, 32'h0, 0, none);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      issue(row.cmd, row.key, row.age, row.score, row.typed, row.want,
            (k == directed_rows.size() - 1) ? 1 + pick_gap(0) : pick_gap(0));
    end

    // random phases, each under its own capacity setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_capacity(cap_plan[p]);
      quiet = (p % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        cmd = (r < 38) ? CMD_INSERT : (r < 68) ? CMD_LOOKUP : (r < 94) ? CMD_DELETE : CMD_NOP;
        r = $urandom_range(0, 9);
        age = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom());
        issue(cmd, pick_key(), age, $urandom(), 0, none,
              (i == PHASE_ITEMS - 1) ? 1 + pick_gap(quiet) : pick_gap(quiet));
      end
    end

    // drain, then watch for stray beats
    for (n = 0; n < 2000 && (pending_replies.size() != 0 || busy !== 1'b0); n++)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected results never arrived", pending_replies.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
